FILE: hw/rtl/fpm_pkg.sv
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared widths and constants for the single-precision multiplier.
// ----------------------------------------------------------------------------
package fpm_pkg;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned EXP_W   = 8;
   localparam int unsigned FRAC_W  = 23;
   localparam int unsigned SIG_W   = 24;
   localparam int unsigned PROD_W  = 48;
   localparam int unsigned XEXP_W  = 10;   // signed working exponent
   localparam logic signed [XEXP_W-1:0] EXP_BIAS = 10'sd127;
   localparam logic signed [XEXP_W-1:0] EXP_MAX  = 10'sd255;
   localparam int unsigned DEFAULT_SKID = 2;

   typedef struct packed {
      logic                     sign;
      logic signed [XEXP_W-1:0] exp;
      logic [PROD_W-1:0]        prod;
   } mul_stage_type;
endpackage

FILE: hw/rtl/fpm_round.sv
// ----------------------------------------------------------------------------
// fpm_round
// Normalize, round to nearest even, and pack with overflow / underflow.
// Two register stages; advances when en is high.
// ----------------------------------------------------------------------------
module fpm_round (
   input  logic                  clock,
   input  logic                  en,
   input  fpm_pkg::mul_stage_type d,
   output logic [31:0]           product,
   output logic                  overflowed,
   output logic                  underflowed
);
   import fpm_pkg::*;

   logic                     sign_ff;
   logic signed [XEXP_W-1:0] exp_ff, exp_in;
   logic [SIG_W-1:0]         sig_ff, sig_in;
   logic [SIG_W-1:0]         nsig;
   logic                     rnd, sticky;
   logic [SIG_W:0]           inc;
   logic [4:0]               sh;
   logic [SIG_W-1:0]         dsig;
   logic [31:0]              product_ff, product_in;
   logic                     ovf_ff, ovf_in, unf_ff, unf_in;

   always_comb begin
      if (d.prod[PROD_W-1]) begin
         nsig   = d.prod[47:24];
         rnd    = d.prod[23];
         sticky = |d.prod[22:0];
         exp_in = d.exp + 10'sd1;
      end else begin
         nsig   = d.prod[46:23];
         rnd    = d.prod[22];
         sticky = |d.prod[21:0];
         exp_in = d.exp;
      end
      inc    = {1'b0, nsig} + {{SIG_W{1'b0}}, (rnd & (sticky | nsig[0]))};
      sig_in = inc[SIG_W] ? inc[SIG_W:1] : inc[SIG_W-1:0];
      if (inc[SIG_W]) exp_in = exp_in + 10'sd1;
   end

   always_comb begin
      sh = (-exp_ff >= 10'sd24) ? 5'd24 : 5'((-exp_ff));
      dsig = (sh >= 5'd24) ? '0 : (sig_ff >> sh);
      ovf_in = 1'b0;
      unf_in = 1'b0;
      if (exp_ff >= EXP_MAX) begin
         product_in = {sign_ff, 8'hFF, 23'd0};
         ovf_in = 1'b1;
      end else if (exp_ff < 0) begin
         product_in = {sign_ff, 8'd0, dsig[FRAC_W-1:0]};
         unf_in = 1'b1;
      end else begin
         product_in = {sign_ff, exp_ff[EXP_W-1:0], sig_ff[FRAC_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_ff    <= d.sign;
         exp_ff     <= exp_in;
         sig_ff     <= sig_in;
         product_ff <= product_in;
         ovf_ff     <= ovf_in;
         unf_ff     <= unf_in;
      end
   end

   assign product     = product_ff;
   assign overflowed  = ovf_ff;
   assign underflowed = unf_ff;
endmodule

FILE: hw/rtl/fp32_multiplier_unit.sv
// Stages from req accept to the skid: operand, multiply x2, round x2; the skid then drives rsp_valid.
// Throughput: one word per cycle; the pipeline stalls as a whole when rsp is held,
// and a two-entry skid keeps req_ready independent of rsp_ready.
// Reset clears all valid bits and the skid count; data registers are not reset.
// ----------------------------------------------------------------------------
// fp32_multiplier_unit
// Pipelined IEEE 754 single-precision multiplier with valid/ready channels.
// ----------------------------------------------------------------------------
module fp32_multiplier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_product,
   output logic        rsp_overflowed,
   output logic        rsp_underflowed
);
   import fpm_pkg::*;

   localparam int unsigned DEPTH = 5;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             en;
   logic [1:0]       cnt_ff, cnt_in;
   logic [33:0]      skid_ff [2];
   logic [33:0]      res;
   logic             push, pop;

   // stage 1: operands
   logic [31:0] a_ff, b_ff;
   // stage 2: partial products (split 24x12)
   logic                     s2_sign_ff;
   logic signed [XEXP_W-1:0] s2_exp_ff;
   logic [35:0]              pp_lo_ff, pp_hi_ff;
   // stage 3: product
   mul_stage_type            s3_ff, s3_in;
   logic [SIG_W-1:0]         ma, mb;
   logic [31:0]              prod;
   logic                     ovf, unf;

   // hold the pipe when the last stage has a word and the skid is full
   assign en        = !(vld_ff[DEPTH-1] && cnt_ff == 2'd2);
   assign req_ready = en;

   assign ma = {1'b1, a_ff[22:0]};
   assign mb = {1'b1, b_ff[22:0]};

   always_comb begin
      s3_in.sign = s2_sign_ff;
      s3_in.exp  = s2_exp_ff;
      s3_in.prod = {12'd0, pp_lo_ff} + {pp_hi_ff, 12'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= req_operand_a;
         b_ff       <= req_operand_b;
         s2_sign_ff <= a_ff[31] ^ b_ff[31];
         s2_exp_ff  <= $signed({2'b0, a_ff[30:23]}) + $signed({2'b0, b_ff[30:23]})
                       - EXP_BIAS;
         pp_lo_ff   <= ma * {12'd0, mb[11:0]};
         pp_hi_ff   <= ma * {12'd0, mb[23:12]};
         s3_ff      <= s3_in;
      end
   end

   fpm_round u_round (
      .clock      (clock),
      .en         (en),
      .d          (s3_ff),
      .product    (prod),
      .overflowed (ovf),
      .underflowed(unf)
   );

   assign vld_in = {vld_ff[DEPTH-2:0], req_valid};
   assign res    = {prod, ovf, unf};
   assign push   = en & vld_ff[DEPTH-1];
   assign pop    = rsp_valid & rsp_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (en) vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   // two-entry fifo, head at index 0
   always_ff @(posedge clock) begin
      if (pop) begin
         if (push && cnt_ff == 2'd1) skid_ff[1'b0] <= res;
         else skid_ff[1'b0] <= skid_ff[1'b1];
         if (push && cnt_ff == 2'd2) skid_ff[1'b1] <= res;
      end else if (push) begin
         skid_ff[cnt_ff[0]] <= res;
      end
   end

   assign rsp_valid       = cnt_ff != 2'd0;
   assign rsp_product     = skid_ff[0][33:2];
   assign rsp_overflowed  = skid_ff[0][1];
   assign rsp_underflowed = skid_ff[0][0];

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("skid overfilled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflowed && rsp_underflowed))
      else $error("both flags set");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |-> !push)
      else $error("push into full skid");
`endif
endmodule

FILE: test/tb_fp32_multiplier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fp32_multiplier_unit
// Drives operand pairs into the single-precision multiplier under random
// backpressure and checks each product and flag against a typed-in value or a local predictor.
// ----------------------------------------------------------------------------
module tb_fp32_multiplier_unit;
   import fpm_pkg::*;

   localparam int N_RANDOM   = 800;
   localparam int WATCH_MAX  = 20000;
   localparam int LATENCY    = 5;

   typedef struct packed {
      logic [31:0] product;
      logic        overflowed;
      logic        underflowed;
   } mul_result_type;

   typedef struct {
      logic [31:0]    a;
      logic [31:0]    b;
      logic           known;   // expected value typed in
      mul_result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_product;
   logic        rsp_overflowed;
   logic        rsp_underflowed;

   mul_result_type pending_products[$];
   int          errors = 0;
   int          sent = 0;
   int          got = 0;
   int          n_ovf = 0;
   int          n_unf = 0;
   int          send_idle_pct = 33;
   int          recv_idle_pct = 84;
   bit          recv_hold = 1'b0;
   int          idle_cycles = 0;

   fp32_multiplier_unit dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic mul_result_type predict_product(logic [31:0] a, logic [31:0] b);
      mul_result_type r;
      logic        sgn;
      int          e;
      logic [47:0] p;
      logic [24:0] sig;
      logic        rnd;
      logic        sticky;
      sgn = a[31] ^ b[31];
      e = int'(a[30:23]) + int'(b[30:23]) - 127;
      p = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
      if (p[47]) begin
         sig = {1'b0, p[47:24]};
         rnd = p[23];
         sticky = |p[22:0];
         e = e + 1;
      end else begin
         sig = {1'b0, p[46:23]};
         rnd = p[22];
         sticky = |p[21:0];
      end
      if (rnd && (sticky || sig[0])) begin
         sig = sig + 1;
         if (sig[24]) begin
            sig = sig >> 1;
            e = e + 1;
         end
      end
      r = '0;
      if (e >= 255) begin
         r.product = {sgn, 31'h7F800000};
         r.overflowed = 1'b1;
      end else if (e < 0) begin
         sig = (-e >= 24) ? 25'd0 : (sig >> (-e));
         r.product = {sgn, 8'd0, sig[22:0]};
         r.underflowed = 1'b1;
      end else begin
         r.product = {sgn, e[7:0], sig[22:0]};
      end
      return r;
   endfunction

   // offer one word; hold until accepted
   task automatic send_word(logic [31:0] a, logic [31:0] b, bit known,
                            mul_result_type res);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_products = {pending_products, (known ? res : predict_product(a, b))};
      sent++;
   endtask

   // drop valid after the last word of a burst
   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic drain_all();
      while (pending_products.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      v = $urandom;
      // keep exponents mostly near the bias so products stay in range
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: v[30:23] = 8'(100 + $urandom_range(54));
         6: v[30:23] = 8'($urandom_range(20));
         7: v[30:23] = 8'(235 + $urandom_range(20));
         default: ;
      endcase
      return v;
   endfunction

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // checker and watchdog
   always @(posedge clock) begin
      mul_result_type exp_r;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCH_MAX) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     pending_products.size());
            $display("Test completed with failures");
            $finish;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got++;
         if (rsp_overflowed) n_ovf++;
         if (rsp_underflowed) n_unf++;
         if (pending_products.size() == 0) begin
            $display("%0t: unexpected word product=%h", $time, rsp_product);
            errors++;
         end else begin
            exp_r = pending_products.pop_front();
            if (rsp_product !== exp_r.product) begin
               $display("%0t: product expected %h actual %h", $time, exp_r.product,
                        rsp_product);
               errors++;
            end
            if (rsp_overflowed !== exp_r.overflowed) begin
               $display("%0t: overflowed expected %b actual %b", $time,
                        exp_r.overflowed, rsp_overflowed);
               errors++;
            end
            if (rsp_underflowed !== exp_r.underflowed) begin
               $display("%0t: underflowed expected %b actual %b", $time,
                        exp_r.underflowed, rsp_underflowed);
               errors++;
            end
         end
      end
   end

   stim_row_type directed[] = '{
      '{32'h3F800000, 32'h3F800000, 1'b1, '{32'h3F800000, 1'b0, 1'b0}},
      '{32'hBF800000, 32'h3F800000, 1'b1, '{32'hBF800000, 1'b0, 1'b0}},
      '{32'h40000000, 32'h40400000, 1'b1, '{32'h40C00000, 1'b0, 1'b0}},
      '{32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1, '{32'h7F800000, 1'b1, 1'b0}},
      '{32'hFF7FFFFF, 32'h7F7FFFFF, 1'b1, '{32'hFF800000, 1'b1, 1'b0}},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'h7F800000, 1'b1, 1'b0}},
      '{32'h00000000, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, 1'b1}},
      '{32'h80000000, 32'h00000000, 1'b1, '{32'h80000000, 1'b0, 1'b1}},
      '{32'h00800000, 32'h3F000000, 1'b0, '0},   // exponent lands on zero
      '{32'h00800000, 32'h3E800000, 1'b0, '0},   // one-bit denormal shift
      '{32'h3FFFFFFF, 32'h3FFFFFFF, 1'b0, '0},   // top product bit set
      '{32'h3F800001, 32'h3F7FFFFF, 1'b0, '0},   // round bit clear, sticky set
      '{32'h3FC00000, 32'h3FC00001, 1'b0, '0},
      '{32'h3F800001, 32'h3F800001, 1'b0, '0},   // round bit clear, sticky set
      '{32'h3F800003, 32'h3F800001, 1'b0, '0},
      '{32'h7F800000, 32'h3F800000, 1'b0, '0},   // infinity as a normal
      '{32'h7FC00000, 32'h3F800000, 1'b0, '0},   // NaN as a normal
      '{32'h00000001, 32'h00000001, 1'b0, '0},
      '{32'h5F000000, 32'h5F800000, 1'b0, '0},   // exponent reaches 254
      '{32'h5F7FFFFF, 32'h5F7FFFFF, 1'b0, '0},
      '{32'h55555555, 32'hAAAAAAAA, 1'b0, '0}
   };

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_word(directed[i].a, directed[i].b, directed[i].known, directed[i].res);
      stop_sending();
      // pause the sender until the pipe is empty
      drain_all();
      // long receiver hold while words keep coming
      recv_hold <= 1'b1;
      fork
         begin
            repeat (60) @(posedge clock);
            recv_hold <= 1'b0;
         end
         repeat (20) send_word(rand_operand(), rand_operand(), 1'b0, '0);
      join
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 84;
            recv_idle_pct = 33;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int k = 0; k < N_RANDOM / 3; k++) begin
            if ($urandom_range(15) == 0) send_word($urandom, $urandom, 1'b0, '0);
            else send_word(rand_operand(), rand_operand(), 1'b0, '0);
         end
      end
      stop_sending();
      drain_all();
      repeat (LATENCY * 4) @(posedge clock);
      $display("Sent %0d operand pairs, checked %0d products (%0d overflowed, %0d underflowed).",
               sent, got, n_ovf, n_unf);
      if (errors == 0 && pending_products.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

FILE: filelist.f
hw/rtl/fpm_pkg.sv
hw/rtl/fpm_round.sv
hw/rtl/fp32_multiplier_unit.sv
test/tb_fp32_multiplier_unit.sv
